@@ rtl/frqs_pkg.sv @@
// Package for the fiber run queue scheduler: sizes, operation, status,
// error and sequencer state codes. No dependencies.
package frqs_pkg;

    localparam int NUM_FIBERS = 16;
    localparam int FIBER_W    = $clog2(NUM_FIBERS);
    localparam int CNT_W      = $clog2(NUM_FIBERS + 1);
    localparam int OP_W       = 3;
    localparam int ID_W       = 4;
    localparam int ERR_W      = 2;
    localparam int STATUS_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 3'd0,
        OP_YIELD  = 3'd1,
        OP_WAIT   = 3'd2,
        OP_NOTIFY = 3'd3,
        OP_FINISH = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_UNUSED   = 3'd0,
        ST_WEAK     = 3'd1,
        ST_STRONG   = 3'd2,
        ST_WAIT     = 3'd3,
        ST_FINISHED = 3'd4
    } status_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK   = 2'd0,
        ERR_IDLE = 2'd1,
        ERR_LIVE = 2'd2
    } err_t;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } fsm_t;

endpackage

@@ rtl/frqs_if.sv @@
// Valid/ready channel interfaces for the command and response beats.
// Depends on frqs_pkg for field widths.
interface frqs_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [frqs_pkg::OP_W-1:0]   operation;
    logic [frqs_pkg::ID_W-1:0]   target_fiber;

    modport source (output valid, output operation, output target_fiber, input ready);
    modport sink   (input valid, input operation, input target_fiber, output ready);
endinterface

interface frqs_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [frqs_pkg::ID_W-1:0]   running_fiber;
    logic                        switched;
    logic [frqs_pkg::ERR_W-1:0]  error_code;

    modport source (output valid, output running_fiber, output switched,
                    output error_code, input ready);
    modport sink   (input valid, input running_fiber, input switched,
                    input error_code, output ready);
endinterface

@@ rtl/frqs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

@@ rtl/fiber_run_queue_scheduler.sv @@
// Top level of the fiber run queue scheduler: sequencer, queue pointers and
// response register. Depends on frqs_pkg, frqs_if and frqs_ram.
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------
//  cmd     | in  | operation, target_fiber
//  rsp     | out | running_fiber, switched, error_code
//
// Each command has a read step, which reads the status memory and the queue
// head, and a decide step, which decides and writes back. The registered
// read data of the status memory sets that split. Reset leaves every fiber
// unused (per-entry valid bits), the queue empty and the idle fiber running;
// no clearing pass. A stalled response holds the sequencer in its decide
// step, and a new command is taken only after the decide step has finished.
module fiber_run_queue_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    frqs_cmd_if.sink    cmd,
    frqs_rsp_if.source  rsp
);

    localparam int FW = frqs_pkg::FIBER_W;
    localparam int CW = frqs_pkg::CNT_W;

    // Sequencer and queue control state
    frqs_pkg::fsm_t          state_reg, state_next;
    logic [FW-1:0]           cur_reg, cur_next;
    logic [FW-1:0]           head_reg, head_next;
    logic [FW-1:0]           tail_reg, tail_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [frqs_pkg::NUM_FIBERS-1:0] valid_reg, valid_next;

    // Latched command
    frqs_pkg::op_t           op_reg;
    logic [frqs_pkg::ID_W-1:0] tgt_reg;
    logic [FW-1:0]           stat_addr_reg;

    // Response register
    logic                    rsp_valid_reg, rsp_valid_next;
    logic [frqs_pkg::ID_W-1:0] rsp_fiber_reg;
    logic                    rsp_switched_reg;
    logic [frqs_pkg::ERR_W-1:0] rsp_err_reg;

    // Memory ports
    logic                    st_we, st_re;
    logic [FW-1:0]           st_raddr;
    logic [frqs_pkg::STATUS_W-1:0] st_wdata, st_rdata;
    logic                    q_we, q_re;
    logic [FW-1:0]           q_wdata, q_rdata;

    // Decide-step signals
    logic                    accept;
    logic                    proceed;
    frqs_pkg::status_t       st;
    frqs_pkg::err_t          err;
    logic                    bad_tgt;
    logic                    wr_st;
    frqs_pkg::status_t       wr_val;
    logic                    push, push_ok, sched, pop;
    logic [FW-1:0]           push_id;
    logic [CW-1:0]           cnt1;
    logic [FW-1:0]           head_inc, tail_inc;

    frqs_ram #(.WIDTH(frqs_pkg::STATUS_W), .DEPTH(frqs_pkg::NUM_FIBERS)) u_status_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (stat_addr_reg),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    frqs_ram #(.WIDTH(FW), .DEPTH(frqs_pkg::NUM_FIBERS)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_reg),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    assign cmd.ready         = (state_reg == frqs_pkg::S_IDLE);
    assign accept            = cmd.valid && cmd.ready;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.running_fiber = rsp_fiber_reg;
    assign rsp.switched      = rsp_switched_reg;
    assign rsp.error_code    = rsp_err_reg;

    // Read the status of the target for create and notify, else of the
    // running fiber; read the queue head alongside.
    assign st_re    = accept;
    assign q_re     = accept;
    assign st_raddr = (cmd.operation == frqs_pkg::OP_CREATE ||
                       cmd.operation == frqs_pkg::OP_NOTIFY)
                      ? FW'(cmd.target_fiber) : cur_reg;

    assign head_inc = (head_reg == FW'(frqs_pkg::NUM_FIBERS - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == FW'(frqs_pkg::NUM_FIBERS - 1)) ? '0 : tail_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= frqs_pkg::S_IDLE;
            cur_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers: command latch and response beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= frqs_pkg::op_t'(cmd.operation);
            tgt_reg       <= cmd.target_fiber;
            stat_addr_reg <= st_raddr;
        end
        if (proceed)
        begin
            rsp_fiber_reg    <= frqs_pkg::ID_W'(cur_next);
            rsp_switched_reg <= (cur_next != cur_reg);
            rsp_err_reg      <= err;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        proceed        = 1'b0;

        // An entry never written reads as unused
        st      = valid_reg[stat_addr_reg] ? frqs_pkg::status_t'(st_rdata)
                                           : frqs_pkg::ST_UNUSED;
        bad_tgt = (tgt_reg == '0) || (32'(tgt_reg) >= frqs_pkg::NUM_FIBERS);
        err     = frqs_pkg::ERR_OK;
        wr_st   = 1'b0;
        wr_val  = frqs_pkg::ST_UNUSED;
        push    = 1'b0;
        push_id = cur_reg;
        sched   = 1'b0;

        unique case (op_reg)
            frqs_pkg::OP_CREATE:
            begin
                push_id = FW'(tgt_reg);
                if (bad_tgt)
                begin
                    err = frqs_pkg::ERR_IDLE;
                end
                else if (st != frqs_pkg::ST_UNUSED && st != frqs_pkg::ST_FINISHED)
                begin
                    err = frqs_pkg::ERR_LIVE;
                end
                else
                begin
                    wr_st  = 1'b1;
                    wr_val = frqs_pkg::ST_WEAK;
                    push   = 1'b1;
                end
            end
            frqs_pkg::OP_YIELD:
            begin
                sched = 1'b1;
                push  = (cur_reg != '0) &&
                        (st == frqs_pkg::ST_WEAK || st == frqs_pkg::ST_STRONG);
            end
            frqs_pkg::OP_WAIT:
            begin
                if (cur_reg == '0)
                begin
                    err = frqs_pkg::ERR_IDLE;
                end
                else if (st == frqs_pkg::ST_WEAK)
                begin
                    wr_st  = 1'b1;
                    wr_val = frqs_pkg::ST_WAIT;
                    sched  = 1'b1;
                end
                else if (st == frqs_pkg::ST_STRONG)
                begin
                    // consume the early wakeup and keep running
                    wr_st  = 1'b1;
                    wr_val = frqs_pkg::ST_WEAK;
                end
            end
            frqs_pkg::OP_NOTIFY:
            begin
                push_id = FW'(tgt_reg);
                if (bad_tgt)
                begin
                    err = frqs_pkg::ERR_IDLE;
                end
                else if (st == frqs_pkg::ST_WEAK)
                begin
                    wr_st  = 1'b1;
                    wr_val = frqs_pkg::ST_STRONG;
                end
                else if (st == frqs_pkg::ST_WAIT)
                begin
                    wr_st  = 1'b1;
                    wr_val = frqs_pkg::ST_WEAK;
                    push   = 1'b1;
                end
            end
            frqs_pkg::OP_FINISH:
            begin
                if (cur_reg == '0)
                begin
                    err = frqs_pkg::ERR_IDLE;
                end
                else
                begin
                    wr_st  = 1'b1;
                    wr_val = frqs_pkg::ST_FINISHED;
                    sched  = 1'b1;
                end
            end
            default:
            begin
                // unknown operation: no change
            end
        endcase

        // Push first, then pop; drop a push into a full queue
        push_ok = push && (count_reg < CW'(frqs_pkg::NUM_FIBERS));
        cnt1    = count_reg + CW'(push_ok);
        pop     = sched && (cnt1 != '0);

        unique case (state_reg)
            frqs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = frqs_pkg::S_EXEC;
                end
            end
            frqs_pkg::S_EXEC:
            begin
                // hold while the previous response beat is still stalled
                if (!rsp_valid_reg || rsp.ready)
                begin
                    proceed        = 1'b1;
                    state_next     = frqs_pkg::S_IDLE;
                    rsp_valid_next = 1'b1;
                    count_next     = cnt1 - CW'(pop);
                    if (push_ok)
                    begin
                        tail_next = tail_inc;
                    end
                    if (pop)
                    begin
                        head_next = head_inc;
                    end
                    if (wr_st)
                    begin
                        valid_next[stat_addr_reg] = 1'b1;
                    end
                    if (sched)
                    begin
                        // an empty queue hands back the fiber just pushed
                        if (cnt1 == '0)
                        begin
                            cur_next = '0;
                        end
                        else if (count_reg == '0)
                        begin
                            cur_next = push_id;
                        end
                        else
                        begin
                            cur_next = q_rdata;
                        end
                    end
                end
            end
            default:
            begin
                state_next = frqs_pkg::S_IDLE;
            end
        endcase

        st_we    = proceed && wr_st;
        st_wdata = wr_val;
        q_we     = proceed && push_ok;
        q_wdata  = push_id;
    end

`ifndef NO_ASSERTIONS
    // The run queue holds fewer entries than there are fibers
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CW'(frqs_pkg::NUM_FIBERS))
        else $error("run queue count out of range");

    // An empty queue has its pointers together
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("queue pointers disagree with count");

    // A stalled response holds the decide step and the queue state
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == frqs_pkg::S_EXEC && rsp_valid_reg && !rsp.ready)
        |=> (state_reg == frqs_pkg::S_EXEC && $stable(count_reg) && $stable(cur_reg)))
        else $error("decide step advanced under a stalled response");
`endif

endmodule
